[src/brm_pkg.sv]
// shared types and constants for the boundary reflectivity meter
package brm_pkg;

    localparam int NUM_AMP    = 8;
    localparam int NUM_ACC    = 4;
    localparam int AMP_IDX_W  = 3;
    localparam int ACC_IDX_W  = 2;
    localparam int FRAC_BITS  = 12;
    localparam int INT_BITS   = 4;
    localparam int RATIO_BITS = FRAC_BITS + INT_BITS;
    localparam int DIV_CNT_W  = $clog2(RATIO_BITS + 1);

    localparam logic [RATIO_BITS-1:0] LIMIT_RESET = 16'd40960;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    // accumulator indexes
    localparam logic [ACC_IDX_W-1:0] ACC_LEFT_INC   = 2'd0;
    localparam logic [ACC_IDX_W-1:0] ACC_LEFT_REFL  = 2'd1;
    localparam logic [ACC_IDX_W-1:0] ACC_RIGHT_INC  = 2'd2;
    localparam logic [ACC_IDX_W-1:0] ACC_RIGHT_REFL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC_LAST,
        S_DIV_L,
        S_WAIT_L,
        S_DIV_R,
        S_WAIT_R,
        S_EMIT
    } brm_state_t;

    typedef struct packed {
        logic                 mul_en;
        logic [ACC_IDX_W-1:0] acc_sel;
        logic                 clear;
    } brm_acc_ctrl_t;

endpackage

[src/brm_sq_acc.sv]
// shared squarer and the four saturating energy accumulators
module brm_sq_acc
    import brm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 56
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  brm_acc_ctrl_t                       ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic [NUM_ACC-1:0][ACC_BITS-1:0]    acc
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;

    logic [SAMPLE_BITS-1:0]               mag;
    logic [PROD_W-1:0]                    prod_reg;
    logic [ACC_IDX_W-1:0]                 prod_sel_reg;
    logic                                 prod_valid_reg;
    logic [NUM_ACC-1:0][ACC_BITS-1:0]     acc_reg;
    logic [SUM_W-1:0]                     sum;
    logic                                 sat;

    // magnitude as unsigned, most negative code maps to 2^(n-1)
    assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    always_ff @(posedge clk)
    begin
        prod_reg     <= PROD_W'(mag) * PROD_W'(mag);
        prod_sel_reg <= ctrl.acc_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
        end
    end

    assign sum = SUM_W'(acc_reg[prod_sel_reg]) + SUM_W'(prod_reg);
    assign sat = |sum[SUM_W-1:ACC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg[prod_sel_reg] <= sat ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
        end
    end

    assign acc = acc_reg;

endmodule

[src/brm_ratio_div.sv]
// bit-serial restoring divider for one reflectivity ratio with limit check
module brm_ratio_div
    import brm_pkg::*;
#(
    parameter int ACC_BITS = 56
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ACC_BITS-1:0]     refl,
    input  logic [ACC_BITS-1:0]     inc,
    input  logic [RATIO_BITS-1:0]   limit,
    output logic                    done,
    output logic [RATIO_BITS-1:0]   ratio
);

    logic                   busy_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   done_reg;
    logic [ACC_BITS-1:0]    d_reg;
    logic [ACC_BITS-1:0]    r_reg;
    logic [RATIO_BITS-1:0]  bring_reg;
    logic [RATIO_BITS-1:0]  q_reg;
    logic [RATIO_BITS-1:0]  limit_reg;
    logic                   zero_reg;
    logic [RATIO_BITS-1:0]  ratio_reg;

    logic [ACC_BITS:0]      trial;
    logic [ACC_BITS+1:0]    diff;
    logic                   ge;
    logic                   over;
    logic                   too_big;

    // ratio of 16.0 or more never fits
    assign too_big = {INT_BITS'(0), refl} >= {inc, INT_BITS'(0)};

    assign trial = {r_reg, bring_reg[RATIO_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};
    assign ge    = ~diff[ACC_BITS+1];

    assign over = zero_reg || (q_reg > limit_reg)
                  || ((q_reg == limit_reg) && (r_reg != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(RATIO_BITS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            d_reg     <= inc;
            r_reg     <= refl >> INT_BITS;
            bring_reg <= {refl[INT_BITS-1:0], FRAC_BITS'(0)};
            q_reg     <= '0;
            limit_reg <= limit;
            zero_reg  <= (inc == '0) || too_big;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_CNT_W'(RATIO_BITS))
            begin
                ratio_reg <= over ? '0 : q_reg;
            end
            else
            begin
                r_reg     <= ge ? diff[ACC_BITS-1:0] : trial[ACC_BITS-1:0];
                q_reg     <= {q_reg[RATIO_BITS-2:0], ge};
                bring_reg <= {bring_reg[RATIO_BITS-2:0], 1'b0};
            end
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

[src/boundary_reflectivity_meter_top.sv]
// top level of the boundary reflectivity meter: sequencer, config and output register
//
// Reflectivity meter for the left and right boundaries. A sample item (kind 0)
// carries eight signed boundary amplitudes; the block squares them one at a time
// on a single shared multiplier and adds each pair into one of four saturating
// energy accumulators (left incident, left reflected, right incident, right
// reflected). After accepting a sample item the block squares the amplitudes in
// turn, then lets the last product land before the next accept. It gives no result.
// A dump item (kind 1) runs a 16-step restoring divider twice, left then right,
// and emits one item with both Q4.12 ratios; a ratio is zero when the incident
// energy is zero or the ratio is above ratio_limit. The accumulators are cleared
// as the result is loaded. in_stall is high while an item is in work; one finished
// result can wait in the output register while the next item is taken. ratio_limit
// is written through cfg_wr_en / cfg_wr_data and resets to 10.0; the user must
// write it only while the block is idle, as the block does not enforce this.
module boundary_reflectivity_meter_top
    import brm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 56
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic signed [SAMPLE_BITS-1:0]   left_fp,
    input  logic signed [SAMPLE_BITS-1:0]   left_gm,
    input  logic signed [SAMPLE_BITS-1:0]   left_fm,
    input  logic signed [SAMPLE_BITS-1:0]   left_gp,
    input  logic signed [SAMPLE_BITS-1:0]   right_fm,
    input  logic signed [SAMPLE_BITS-1:0]   right_gp,
    input  logic signed [SAMPLE_BITS-1:0]   right_fp,
    input  logic signed [SAMPLE_BITS-1:0]   right_gm,

    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [RATIO_BITS-1:0]           reflect_left,
    output logic [RATIO_BITS-1:0]           reflect_right,

    // ratio_limit register
    input  logic                            cfg_wr_en,
    input  logic [RATIO_BITS-1:0]           cfg_wr_data
);

    brm_state_t                         state_reg, state_next;
    logic [AMP_IDX_W-1:0]               cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0]      sample_reg [NUM_AMP];
    logic [RATIO_BITS-1:0]              limit_reg;
    logic [RATIO_BITS-1:0]              left_ratio_reg;
    logic                               out_valid_reg;
    logic [RATIO_BITS-1:0]              reflect_left_reg;
    logic [RATIO_BITS-1:0]              reflect_right_reg;

    logic                               in_accept;
    logic                               out_free;
    logic                               emit;
    brm_acc_ctrl_t                      acc_ctrl;
    logic [NUM_ACC-1:0][ACC_BITS-1:0]   acc;
    logic                               div_start;
    logic                               div_side;
    logic                               div_done;
    logic [RATIO_BITS-1:0]              div_ratio;
    logic [ACC_BITS-1:0]                div_refl;
    logic [ACC_BITS-1:0]                div_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // capture the item, amplitudes ordered by accumulator pairs
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg[0] <= left_fp;
            sample_reg[1] <= left_gm;
            sample_reg[2] <= left_fm;
            sample_reg[3] <= left_gp;
            sample_reg[4] <= right_fm;
            sample_reg[5] <= right_gp;
            sample_reg[6] <= right_fp;
            sample_reg[7] <= right_gm;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        acc_ctrl.mul_en  = 1'b0;
        acc_ctrl.acc_sel = cnt_reg[AMP_IDX_W-1:1];
        acc_ctrl.clear   = 1'b0;
        div_start        = 1'b0;
        div_side         = 1'b0;
        emit             = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    state_next = (kind == KIND_DUMP) ? S_DIV_L : S_SQ;
                end
            end
            S_SQ:
            begin
                // square one amplitude per cycle
                acc_ctrl.mul_en = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == AMP_IDX_W'(NUM_AMP - 1))
                begin
                    state_next = S_ACC_LAST;
                end
            end
            S_ACC_LAST:
            begin
                // last product lands in its accumulator
                state_next = S_IDLE;
            end
            S_DIV_L:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT_L;
            end
            S_WAIT_L:
            begin
                if (div_done)
                begin
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                div_start  = 1'b1;
                div_side   = 1'b1;
                state_next = S_WAIT_R;
            end
            S_WAIT_R:
            begin
                div_side = 1'b1;
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait for room in the output register, then clear energies
                if (out_free)
                begin
                    emit           = 1'b1;
                    acc_ctrl.clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    brm_sq_acc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_sq_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (sample_reg[cnt_reg]),
        .acc    (acc)
    );

    // divider operands: left pair, then right pair
    assign div_refl = div_side ? acc[ACC_RIGHT_REFL] : acc[ACC_LEFT_REFL];
    assign div_inc  = div_side ? acc[ACC_RIGHT_INC]  : acc[ACC_LEFT_INC];

    brm_ratio_div #(
        .ACC_BITS (ACC_BITS)
    ) u_ratio_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .refl  (div_refl),
        .inc   (div_inc),
        .limit (limit_reg),
        .done  (div_done),
        .ratio (div_ratio)
    );

    // hold the left ratio while the right one is worked out
    always_ff @(posedge clk)
    begin
        if (div_done && !div_side)
        begin
            left_ratio_reg <= div_ratio;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            reflect_left_reg  <= left_ratio_reg;
            reflect_right_reg <= div_ratio;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reflect_left  = reflect_left_reg;
    assign reflect_right = reflect_right_reg;

endmodule

[src/brm_checker.sv]
// port-level checks for the boundary reflectivity meter and their binding
module brm_checker
    import brm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   kind,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [RATIO_BITS-1:0]  reflect_left,
    input logic [RATIO_BITS-1:0]  reflect_right
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reflect_left)
                                   && $stable(reflect_right))
        else $error("stalled result changed");

    // busy right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // a sample item never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_SAMPLE) |=> !$rose(out_valid))
        else $error("result after sample item");

    // results only come out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

endmodule

bind boundary_reflectivity_meter_top brm_checker u_brm_checker (.*);
